[hw/rtl/gscr_pkg.sv]
// Shared types and codes for the sparse GF(2) column reducer.
package gscr_pkg;

  localparam int ROW_W = 10;
  localparam int COL_W = 11;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_CLOSE  = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_LOW    = 3'd3;
  localparam logic [2:0] OP_TWIST  = 3'd4;
  localparam logic [2:0] OP_SPACE  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [COL_W-1:0] COL_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [ROW_W-1:0] row_value;
    logic [ROW_W-1:0] target_column;
    logic [COL_W-1:0] source_column;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] low_row;
    logic             space_ok;
    logic [1:0]       status;
  } out_item_t;

endpackage

[hw/rtl/gscr_col_table.sv]
// Column start/end pointer tables with a shared registered read address.
module gscr_col_table #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ENTRIES = 8192
) (
  input  logic                               clk,
  input  logic [$clog2(MAX_COLUMNS)-1:0]     rd_addr,
  input  logic                               st_we,
  input  logic [$clog2(MAX_COLUMNS)-1:0]     st_waddr,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   st_wdata,
  input  logic                               en_we,
  input  logic [$clog2(MAX_COLUMNS)-1:0]     en_waddr,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   en_wdata,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   start_q,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   end_q
);

  localparam int CAW = $clog2(MAX_COLUMNS);
  localparam int EW  = $clog2(MAX_ENTRIES+1);

  logic [EW-1:0]  start_mem [MAX_COLUMNS];
  logic [EW-1:0]  end_mem   [MAX_COLUMNS];
  logic [EW-1:0]  start_rd_r;
  logic [CAW-1:0] rd_addr_r;

  // start table: column 0 always begins at entry 0 and is never written
  always_ff @(posedge clk) begin
    if (st_we) begin
      start_mem[st_waddr] <= st_wdata;
    end
    start_rd_r <= start_mem[rd_addr];
    rd_addr_r  <= rd_addr;
  end

  // end table
  always_ff @(posedge clk) begin
    if (en_we) begin
      end_mem[en_waddr] <= en_wdata;
    end
    end_q <= end_mem[rd_addr];
  end

  assign start_q = (rd_addr_r == '0) ? '0 : start_rd_r;

endmodule

[hw/rtl/gf2_sparse_column_reducer.sv]
// Sparse GF(2) column reducer: loader, column add, low query, twist sweep, space check.
// Column add checks range, merges, then copies the merged list back over the target; a range
// error skips the merge and no space skips the copy; twist visits every column in turn.
// One item at a time, next one taken in the strobe cycle; results are never stalled.
// Reset (synchronous, rst_n low) empties the loader and sets column_count to 1024.
module gf2_sparse_column_reducer #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ENTRIES = 8192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  gscr_pkg::in_item_t        in_data,
  output logic                      out_valid,
  output gscr_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gscr_pkg::COL_W-1:0] cfg_data
);

  import gscr_pkg::*;

  localparam int CAW = $clog2(MAX_COLUMNS);
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int EW  = $clog2(MAX_ENTRIES+1);
  localparam int KW  = EW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_T1, S_T2, S_T3, S_T4, S_EVAL,
    S_MRD, S_MCMP, S_MEND, S_CRD, S_CWR, S_CEND,
    S_WA, S_WB, S_WC, S_WD, S_LA, S_LB, S_LC
  } state_t;

  state_t           state_r;
  logic [COL_W-1:0] cfg_r;
  logic [COL_W-1:0] load_r;
  logic [EW-1:0]    entries_r;
  in_item_t         item_r;
  out_item_t        out_r;
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic             ok_r;
  logic [EW-1:0]    stt_r, ent_r, stn_r, sts_r, ens_r;
  logic [EW-1:0]    i_r, j_r, e1_r, e2_r, base_r, idx_r;
  logic [KW-1:0]    k_r;
  logic [COL_W-1:0] c_r, lo_r;

  logic [COL_W-1:0] n_cols;
  logic [COL_W-1:0] t_col, t_next, s_col, lo_col;
  logic             closed_t, closed_s, closed_c, closed_lo;
  logic [EW-1:0]    len_t, cap_t, len_s, sub_s, max_m;
  logic [KW-1:0]    need;
  logic             load_ok, append_ok;

  // memory ports
  logic [CAW-1:0]   tab_rd_addr;
  logic             st_we, en_we;
  logic [CAW-1:0]   st_waddr, en_waddr;
  logic [EW-1:0]    st_wdata, en_wdata;
  logic [EW-1:0]    start_q, end_q;

  logic [ROW_W-1:0] row_store [MAX_ENTRIES];
  logic [ROW_W-1:0] merge_buffer [MAX_ENTRIES];
  logic [AW-1:0]    rsa_addr, rsb_addr, rs_waddr, mb_addr, mb_waddr;
  logic [ROW_W-1:0] rsa_q, rsb_q, mb_q, rs_wdata, mb_wdata;
  logic             rs_we, mb_we;

  // merge step decision
  logic             a_ok, b_ok, m_eq, take_a;
  logic [ROW_W-1:0] m_val;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // columns in use, clamped to the table depth
  always_comb begin
    if ((MAX_COLUMNS < 2048) && ({21'd0, cfg_r} > MAX_COLUMNS)) begin
      n_cols = COL_W'(MAX_COLUMNS);
    end else begin
      n_cols = cfg_r;
    end
  end

  // per-column facts
  assign t_col     = {1'b0, item_r.target_column};
  assign t_next    = t_col + 11'd1;
  assign s_col     = item_r.source_column;
  assign lo_col    = {1'b0, rsa_q};
  assign closed_t  = (t_col < n_cols) && (t_col < load_r);
  assign closed_s  = (s_col < n_cols) && (s_col < load_r);
  assign closed_c  = (c_r < n_cols) && (c_r < load_r);
  assign closed_lo = (lo_col < n_cols) && (lo_col < load_r);
  assign len_t     = closed_t ? (ent_r - stt_r) : '0;
  assign len_s     = closed_s ? (ens_r - sts_r) : '0;
  assign cap_t     = !closed_t ? '0 :
                     (t_next < n_cols) ? (stn_r - stt_r) : (entries_r - stt_r);
  assign sub_s     = (len_s > EW'(2)) ? (len_s - EW'(2)) : '0;
  assign max_m     = (sub_s > len_t) ? sub_s : len_t;
  assign need      = {1'b0, len_t} + {1'b0, max_m};
  assign load_ok   = (load_r < n_cols);
  assign append_ok = load_ok && (entries_r != EW'(MAX_ENTRIES));

  assign a_ok   = (i_r < e1_r);
  assign b_ok   = (j_r < e2_r);
  assign m_eq   = a_ok && b_ok && (rsa_q == rsb_q);
  assign take_a = !b_ok || (a_ok && (rsa_q < rsb_q));
  assign m_val  = take_a ? rsa_q : rsb_q;

  // memory control from the sequencer state
  always_comb begin
    tab_rd_addr = CAW'(t_col);
    st_we       = 1'b0;
    st_waddr    = CAW'(load_r + 11'd1);
    st_wdata    = entries_r;
    en_we       = 1'b0;
    en_waddr    = CAW'(load_r);
    en_wdata    = entries_r;
    rsa_addr    = AW'(i_r);
    rsb_addr    = AW'(j_r);
    rs_we       = 1'b0;
    rs_waddr    = AW'(entries_r);
    rs_wdata    = item_r.row_value;
    mb_addr     = AW'(idx_r);
    mb_we       = 1'b0;
    mb_waddr    = AW'(k_r);
    mb_wdata    = m_val;
    case (state_r)
      S_EXEC: begin
        if (item_r.opcode == OP_APPEND) begin
          rs_we = append_ok;
        end
        if (item_r.opcode == OP_CLOSE) begin
          en_we = load_ok;
          st_we = load_ok && ({21'd0, load_r} + 1 < MAX_COLUMNS);
        end
      end
      S_T2:   tab_rd_addr = CAW'(t_next);
      S_T3:   tab_rd_addr = CAW'(s_col);
      S_MCMP: mb_we = !m_eq && (k_r < KW'(MAX_ENTRIES));
      S_CWR: begin
        rs_we    = 1'b1;
        rs_waddr = AW'(idx_r);
        rs_wdata = mb_q;
      end
      S_CEND: begin
        en_we    = 1'b1;
        en_waddr = CAW'(t_col);
        en_wdata = EW'(k_r);
      end
      S_WA:   tab_rd_addr = CAW'(c_r);
      S_WB:   rsa_addr = AW'(end_q - EW'(1));
      S_WC:   tab_rd_addr = CAW'(lo_col);
      S_WD: begin
        en_we    = 1'b1;
        en_waddr = CAW'(lo_r);
        en_wdata = start_q;
      end
      S_LB:   rsa_addr = AW'(end_q - EW'(1));
      default: ;
    endcase
  end

  gscr_col_table #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_col_table (
    .clk      (clk),
    .rd_addr  (tab_rd_addr),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .en_we    (en_we),
    .en_waddr (en_waddr),
    .en_wdata (en_wdata),
    .start_q  (start_q),
    .end_q    (end_q)
  );

  // entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rs_we) begin
      row_store[rs_waddr] <= rs_wdata;
    end
    rsa_q <= row_store[rsa_addr];
    rsb_q <= row_store[rsb_addr];
  end

  // merge buffer
  always_ff @(posedge clk) begin
    if (mb_we) begin
      merge_buffer[mb_waddr] <= mb_wdata;
    end
    mb_q <= merge_buffer[mb_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= COL_COUNT_RESET;
      load_r      <= '0;
      entries_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r   <= in_data;
            status_r <= ST_OK;
            ok_r     <= 1'b0;
            c_r      <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (item_r.opcode)
            OP_APPEND, OP_CLOSE: begin
              if (!load_ok) begin
                out_r.status <= ST_RANGE;
              end else if (item_r.opcode == OP_CLOSE) begin
                out_r.status <= ST_OK;
                load_r       <= load_r + 11'd1;
              end else if (!append_ok) begin
                out_r.status <= ST_FULL;
              end else begin
                out_r.status <= ST_OK;
                entries_r    <= entries_r + EW'(1);
              end
              out_r.low_row  <= n_cols;
              out_r.space_ok <= 1'b0;
              out_valid_r    <= 1'b1;
              state_r        <= S_IDLE;
            end
            OP_ADD, OP_SPACE: state_r <= S_T1;
            OP_LOW:           state_r <= S_LA;
            OP_TWIST:         state_r <= S_WA;
            default: begin
              out_r.low_row  <= n_cols;
              out_r.space_ok <= 1'b0;
              out_r.status   <= ST_OK;
              out_valid_r    <= 1'b1;
              state_r        <= S_IDLE;
            end
          endcase
        end
        // gather target and source pointers
        S_T1: state_r <= S_T2;
        S_T2: begin
          stt_r   <= start_q;
          ent_r   <= end_q;
          state_r <= S_T3;
        end
        S_T3: begin
          stn_r   <= start_q;
          state_r <= S_T4;
        end
        S_T4: begin
          sts_r   <= start_q;
          ens_r   <= end_q;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (item_r.opcode == OP_SPACE) begin
            ok_r    <= (len_t == '0) || (s_col >= n_cols) || (need <= {1'b0, cap_t});
            state_r <= S_LA;
          end else if ((t_col >= n_cols) || (s_col >= n_cols)) begin
            status_r <= ST_RANGE;
            state_r  <= S_LA;
          end else begin
            base_r  <= closed_t ? stt_r : '0;
            i_r     <= closed_t ? stt_r : '0;
            e1_r    <= (closed_t ? stt_r : '0) + len_t;
            j_r     <= closed_s ? sts_r : '0;
            e2_r    <= (closed_s ? sts_r : '0) + len_s;
            k_r     <= {1'b0, (closed_t ? stt_r : EW'(0))};
            state_r <= S_MRD;
          end
        end
        // merge: symmetric difference of two sorted lists
        S_MRD: state_r <= (a_ok || b_ok) ? S_MCMP : S_MEND;
        S_MCMP: begin
          if (m_eq) begin
            i_r <= i_r + EW'(1);
            j_r <= j_r + EW'(1);
          end else begin
            if (take_a) begin
              i_r <= i_r + EW'(1);
            end else begin
              j_r <= j_r + EW'(1);
            end
            k_r <= k_r + KW'(1);
          end
          state_r <= S_MRD;
        end
        S_MEND: begin
          if ((k_r - {1'b0, base_r}) > {1'b0, cap_t}) begin
            status_r <= ST_NOSPACE;
            state_r  <= S_LA;
          end else if (closed_t) begin
            idx_r   <= base_r;
            state_r <= S_CRD;
          end else begin
            state_r <= S_LA;
          end
        end
        // copy merged list back over the target
        S_CRD: state_r <= ({1'b0, idx_r} < k_r) ? S_CWR : S_CEND;
        S_CWR: begin
          idx_r   <= idx_r + EW'(1);
          state_r <= S_CRD;
        end
        S_CEND: state_r <= S_LA;
        // twist sweep over every column
        S_WA: state_r <= (c_r < n_cols) ? S_WB : S_LA;
        S_WB: begin
          if (closed_c && (end_q != start_q)) begin
            state_r <= S_WC;
          end else begin
            c_r     <= c_r + 11'd1;
            state_r <= S_WA;
          end
        end
        S_WC: begin
          lo_r <= lo_col;
          if (closed_lo) begin
            state_r <= S_WD;
          end else begin
            c_r     <= c_r + 11'd1;
            state_r <= S_WA;
          end
        end
        S_WD: begin
          c_r     <= c_r + 11'd1;
          state_r <= S_WA;
        end
        // low of the target, then report
        S_LA: state_r <= S_LB;
        S_LB: begin
          if (closed_t && (end_q != start_q)) begin
            state_r <= S_LC;
          end else begin
            out_r.low_row  <= n_cols;
            out_r.space_ok <= ok_r;
            out_r.status   <= status_r;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        S_LC: begin
          out_r.low_row  <= lo_col;
          out_r.space_ok <= ok_r;
          out_r.status   <= status_r;
          out_valid_r    <= 1'b1;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without a finished item");

  a_space_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.space_ok |-> out_data.status == ST_OK)
    else $error("space answer with error status");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {21'd0, load_r} <= MAX_COLUMNS)
    else $error("loader column past table depth");
`endif

endmodule

[tb/gf2_sparse_column_reducer_check.sv]
// Checker for the sparse GF(2) column reducer: predicts each result and compares it.
`timescale 1ns / 1ps

module gf2_sparse_column_reducer_check #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ENTRIES = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  gscr_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  gscr_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [gscr_pkg::COL_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);

  import gscr_pkg::*;

  // Mirror of the matrix held in the block
  logic [COL_W-1:0] ncol_reg;
  logic [ROW_W-1:0] entry_rows [MAX_ENTRIES];
  logic [ROW_W-1:0] merge_rows [MAX_ENTRIES];
  int unsigned      col_first  [MAX_COLUMNS];
  int unsigned      col_last   [MAX_COLUMNS];
  int unsigned      open_col;
  int unsigned      fill_count;
  out_item_t        expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entry_rows[i] = '0;
      merge_rows[i] = '0;
    end
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      col_first[i] = 0;
      col_last[i]  = 0;
    end
  end

  function automatic int unsigned ncols();
    return (ncol_reg > MAX_COLUMNS) ? MAX_COLUMNS : 32'(ncol_reg);
  endfunction

  function automatic bit is_sealed(int unsigned c);
    return (c < ncols()) && (c < open_col);
  endfunction

  function automatic int unsigned length_of(int unsigned c);
    return is_sealed(c) ? col_last[c] - col_first[c] : 0;
  endfunction

  function automatic int unsigned low_of(int unsigned c);
    if (length_of(c) == 0) return ncols();
    return 32'(entry_rows[col_last[c] - 1]);
  endfunction

  function automatic int unsigned room_of(int unsigned c);
    if (!is_sealed(c)) return 0;
    if (c + 1 < ncols()) return col_first[c + 1] - col_first[c];
    return fill_count - col_first[c];
  endfunction

  // Sorted symmetric difference of target and source, written back if it fits
  function automatic logic [1:0] xor_columns(int unsigned t, int unsigned s);
    int unsigned n, i, e1, j, e2, st, k;
    logic [ROW_W-1:0] v;
    n = ncols();
    if (t >= n || s >= n) return ST_RANGE;
    st = is_sealed(t) ? col_first[t] : 0;
    i  = st;
    e1 = st + length_of(t);
    j  = is_sealed(s) ? col_first[s] : 0;
    e2 = j + length_of(s);
    k  = st;
    while (i < e1 || j < e2) begin
      if (i < e1 && j < e2 && entry_rows[i] == entry_rows[j]) begin
        i++;
        j++;
        continue;
      end
      if (j >= e2 || (i < e1 && entry_rows[i] < entry_rows[j])) begin
        v = entry_rows[i];
        i++;
      end else begin
        v = entry_rows[j];
        j++;
      end
      if (k < MAX_ENTRIES) merge_rows[k] = v;
      k++;
    end
    if (k - st > room_of(t)) return ST_NOSPACE;
    if (is_sealed(t)) begin
      for (i = st; i < k; i++) entry_rows[i] = merge_rows[i];
      col_last[t] = k;
    end
    return ST_OK;
  endfunction

  // Twist: empty each sealed column that is named as some column's low
  function automatic void twist_all();
    int unsigned n, lo;
    n = ncols();
    for (int unsigned c = 0; c < n; c++) begin
      lo = low_of(c);
      if (lo < n && is_sealed(lo)) col_last[lo] = col_first[lo];
    end
  endfunction

  function automatic logic will_fit(int unsigned t, int unsigned s);
    int unsigned len, slen, sub, m;
    len = length_of(t);
    if (len == 0 || s >= ncols()) return 1'b1;
    slen = length_of(s);
    sub  = (slen > 2) ? slen - 2 : 0;
    m    = (sub > len) ? sub : len;
    return (len + m <= room_of(t));
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int unsigned n, tc, sc;
    n  = ncols();
    tc = 32'(it.target_column);
    sc = 32'(it.source_column);
    r.low_row  = n[COL_W-1:0];
    r.space_ok = 1'b0;
    r.status   = ST_OK;
    case (it.opcode)
      OP_APPEND: begin
        if (open_col >= n) r.status = ST_RANGE;
        else if (fill_count >= MAX_ENTRIES) r.status = ST_FULL;
        else begin
          entry_rows[fill_count] = it.row_value;
          fill_count++;
        end
      end
      OP_CLOSE: begin
        if (open_col >= n) r.status = ST_RANGE;
        else begin
          col_last[open_col] = fill_count;
          if (open_col + 1 < MAX_COLUMNS) col_first[open_col + 1] = fill_count;
          open_col++;
        end
      end
      OP_ADD: begin
        r.status  = xor_columns(tc, sc);
        r.low_row = COL_W'(low_of(tc));
      end
      OP_LOW: r.low_row = COL_W'(low_of(tc));
      OP_TWIST: begin
        twist_all();
        r.low_row = COL_W'(low_of(tc));
      end
      OP_SPACE: begin
        r.space_ok = will_fit(tc, sc);
        r.low_row  = COL_W'(low_of(tc));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ncol_reg   = COL_COUNT_RESET;
      open_col   = 0;
      fill_count = 0;
      expected_results.delete();
    end else begin
      // results first: a result at this edge belongs to an earlier item
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.low_row !== want.low_row)
            report_mismatch("low_row", 32'(out_data.low_row), 32'(want.low_row));
          if (out_data.space_ok !== want.space_ok)
            report_mismatch("space_ok", 32'(out_data.space_ok), 32'(want.space_ok));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
      end
      if (cfg_valid && cfg_ready) ncol_reg = cfg_data;
      if (start && !busy) expected_results = {expected_results, apply_item(in_data)};
    end
    pending = expected_results.size();
  end

endmodule

[tb/gf2_sparse_column_reducer_test.sv]
// Top of the column reducer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gf2_sparse_column_reducer_test;
  import gscr_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 30000000;
  localparam int PHASE_ITEMS = 280;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [COL_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               cycles;
  int               burst_left;
  int               sealed_guess;
  int               last_row;

  gf2_sparse_column_reducer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  gf2_sparse_column_reducer_check checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[gf2_sparse_column_reducer] ERROR");
        $finish;
      end
    end
  end

  // One transfer on the command port; sender works in bursts with gaps
  task automatic send_op(logic [2:0] op, int row, int tgt, int src);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data.opcode        <= op;
    in_data.row_value     <= row[ROW_W-1:0];
    in_data.target_column <= tgt[ROW_W-1:0];
    in_data.source_column <= src[COL_W-1:0];
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Hold off until every expected result has come, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_count(int value);
    cfg_data  <= value[COL_W-1:0];
    cfg_valid <= 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_col();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, sealed_guess + 2);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_src();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, sealed_guess + 2);
    return $urandom_range(0, 2047);
  endfunction

  // Mostly ascending rows per column, sometimes arbitrary
  function automatic int next_row();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    last_row = last_row + $urandom_range(1, 60);
    if (last_row > 1023) last_row = $urandom_range(0, 1023);
    return last_row;
  endfunction

  task automatic random_items(int count, int twist_weight);
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 999);
      if (w < 200) begin
        send_op(OP_APPEND, next_row(), pick_col(), pick_src());
      end else if (w < 280) begin
        send_op(OP_CLOSE, $urandom_range(0, 1023), pick_col(), pick_src());
        sealed_guess++;
        last_row = 0;
      end else if (w < 630) begin
        send_op(OP_ADD, $urandom_range(0, 1023), pick_col(), pick_src());
      end else if (w < 750) begin
        send_op(OP_LOW, $urandom_range(0, 1023), pick_col(), pick_src());
      end else if (w < 750 + twist_weight) begin
        send_op(OP_TWIST, $urandom_range(0, 1023), pick_col(), pick_src());
      end else if (w < 980) begin
        send_op(OP_SPACE, $urandom_range(0, 1023), pick_col(), pick_src());
      end else begin
        send_op(w[0] ? OP_SPARE_A : OP_SPARE_B, $urandom_range(0, 1023), pick_col(),
                pick_src());
      end
    end
  endtask

  initial begin
    int counts [6];
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    burst_left   = 0;
    sealed_guess = 3;
    last_row     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty matrix, range checks, spare opcodes
    send_op(OP_LOW,    0,    0,    0);
    send_op(OP_SPACE,  0,    1023, 2047);
    send_op(OP_ADD,    0,    1023, 1024);
    send_op(OP_ADD,    0,    0,    0);
    send_op(OP_TWIST,  0,    0,    0);
    send_op(OP_SPARE_A, 1023, 1023, 2047);
    send_op(OP_SPARE_B, 0,    0,    0);
    // column 0 unsorted, column 1 sorted, column 2 empty
    send_op(OP_APPEND, 0,    0, 0);
    send_op(OP_APPEND, 1023, 0, 0);
    send_op(OP_APPEND, 5,    0, 0);
    send_op(OP_CLOSE,  0,    0, 0);
    send_op(OP_APPEND, 3,    0, 0);
    send_op(OP_APPEND, 1023, 0, 0);
    send_op(OP_CLOSE,  0,    0, 0);
    send_op(OP_CLOSE,  0,    0, 0);
    send_op(OP_ADD,    0,    0, 1);
    send_op(OP_LOW,    0,    0, 0);
    send_op(OP_SPACE,  0,    0, 1);
    send_op(OP_SPACE,  0,    0, 2047);
    send_op(OP_ADD,    0,    1, 1);
    send_op(OP_ADD,    0,    1, 0);
    send_op(OP_TWIST,  0,    2, 0);
    // nonempty result into an unclosed target does not fit
    send_op(OP_ADD,    0,    5, 0);
    wait_idle();

    // No columns at all
    write_count(0);
    send_op(OP_APPEND, 7, 0, 0);
    send_op(OP_CLOSE,  0, 0, 0);
    send_op(OP_LOW,    0, 0, 0);
    send_op(OP_TWIST,  0, 0, 0);
    wait_idle();

    // Random phases over several column counts; each ends with the sender held off
    counts = '{48, 16, 1, 100, 2047, 64};
    foreach (counts[p]) begin
      write_count(counts[p]);
      random_items(PHASE_ITEMS, (counts[p] > 200) ? 2 : 40);
      wait_idle();
    end

    // Full column count, one more loaded column, then a short random run
    write_count(1024);
    last_row = 0;
    send_op(OP_CLOSE, 0, 0, 0);
    sealed_guess++;
    random_items(40, 2);
    wait_idle();

    if (fail_count == 0) begin
      $display("[gf2_sparse_column_reducer] OK");
    end else begin
      $display("[gf2_sparse_column_reducer] ERROR");
    end
    $finish;
  end

endmodule
